// File: src/ohlc_pkg.sv
// Package for the OHLC bar aggregator: widths, bar word types and
// reset constants shared by the merge stage, the output queue and the top level.
// No dependencies.
`default_nettype none

package ohlc_pkg;

  localparam int PRICE_BITS      = 32;
  localparam int VOLUME_SUM_BITS = 48;
  localparam int TIME_BITS       = 48;
  localparam int VOLUME_IN_BITS  = 32;
  localparam int GROUP_BITS      = 16;

  // wide enough to hold the sum of the accumulated and incoming volume
  localparam int VOL_CALC_BITS =
    ((VOLUME_SUM_BITS > VOLUME_IN_BITS) ? VOLUME_SUM_BITS : VOLUME_IN_BITS) + 1;

  localparam logic [GROUP_BITS-1:0] GROUP_SIZE_RST = GROUP_BITS'(2);
  localparam logic [GROUP_BITS-1:0] MIN_GROUP      = GROUP_BITS'(2);

  typedef struct packed {
    logic [TIME_BITS-1:0]      bar_time;
    logic [PRICE_BITS-1:0]     price_open;
    logic [PRICE_BITS-1:0]     price_high;
    logic [PRICE_BITS-1:0]     price_low;
    logic [PRICE_BITS-1:0]     price_close;
    logic [VOLUME_IN_BITS-1:0] bar_volume;
    logic                      end_of_set;
  } bar_in_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]       merged_time;
    logic [PRICE_BITS-1:0]      merged_open;
    logic [PRICE_BITS-1:0]      merged_high;
    logic [PRICE_BITS-1:0]      merged_low;
    logic [PRICE_BITS-1:0]      merged_close;
    logic [VOLUME_SUM_BITS-1:0] merged_volume;
    logic                       final_bar;
  } bar_out_t;

endpackage

`default_nettype wire

// File: src/ohlc_bar_aggregator.sv
// Top level of the OHLC bar aggregator: group size register, merge stage
// and result queue. Depends on ohlc_pkg, ohlc_merge and ohlc_out_fifo.
//
//   port group   direction   handshake             word
//   in_*         input       in_valid/in_ready     one price bar
//   out_*        output      out_valid/out_ready   one merged bar
//   cfg_*        input       cfg_wr_en             group_size (16 bits)
//
// One bar is taken per cycle while in_ready is high. A merged bar reaches out_* through
// the input register, then the result queue, once the bar that closes its group is
// accepted. While both queue words wait, a bar that closes a group holds in the input
// register and in_ready drops; a pop from a full queue frees a word so that it can move on.
// Reset (rst_n low, synchronous) empties both stages, clears the group and
// sets group_size to 2; a group_size of 0 or 1 acts as 2.
`default_nettype none

module ohlc_bar_aggregator (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [ohlc_pkg::GROUP_BITS-1:0]        cfg_wr_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [ohlc_pkg::TIME_BITS-1:0]         in_bar_time,
  input  wire logic [ohlc_pkg::PRICE_BITS-1:0]        in_price_open,
  input  wire logic [ohlc_pkg::PRICE_BITS-1:0]        in_price_high,
  input  wire logic [ohlc_pkg::PRICE_BITS-1:0]        in_price_low,
  input  wire logic [ohlc_pkg::PRICE_BITS-1:0]        in_price_close,
  input  wire logic [ohlc_pkg::VOLUME_IN_BITS-1:0]    in_bar_volume,
  input  wire logic                                   in_end_of_set,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [ohlc_pkg::TIME_BITS-1:0]              out_merged_time,
  output logic [ohlc_pkg::PRICE_BITS-1:0]             out_merged_open,
  output logic [ohlc_pkg::PRICE_BITS-1:0]             out_merged_high,
  output logic [ohlc_pkg::PRICE_BITS-1:0]             out_merged_low,
  output logic [ohlc_pkg::PRICE_BITS-1:0]             out_merged_close,
  output logic [ohlc_pkg::VOLUME_SUM_BITS-1:0]        out_merged_volume,
  output logic                                        out_final_bar
);

  logic [ohlc_pkg::GROUP_BITS-1:0] group_size_r;
  ohlc_pkg::bar_in_t               in_bar;
  ohlc_pkg::bar_out_t              push_bar;
  ohlc_pkg::bar_out_t              out_bar;
  logic                            push_valid;
  logic                            push_space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= ohlc_pkg::GROUP_SIZE_RST;
    end else if (cfg_wr_en) begin
      group_size_r <= cfg_wr_data;
    end
  end

  always_comb begin
    in_bar.bar_time    = in_bar_time;
    in_bar.price_open  = in_price_open;
    in_bar.price_high  = in_price_high;
    in_bar.price_low   = in_price_low;
    in_bar.price_close = in_price_close;
    in_bar.bar_volume  = in_bar_volume;
    in_bar.end_of_set  = in_end_of_set;
  end

  ohlc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .group_size (group_size_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_bar     (in_bar),
    .push_valid (push_valid),
    .push_bar   (push_bar),
    .push_space (push_space)
  );

  ohlc_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_bar   (push_bar),
    .push_space (push_space),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_bar    (out_bar)
  );

  assign out_merged_time   = out_bar.merged_time;
  assign out_merged_open   = out_bar.merged_open;
  assign out_merged_high   = out_bar.merged_high;
  assign out_merged_low    = out_bar.merged_low;
  assign out_merged_close  = out_bar.merged_close;
  assign out_merged_volume = out_bar.merged_volume;
  assign out_final_bar     = out_bar.final_bar;

endmodule

`default_nettype wire

// File: src/ohlc_merge.sv
// Input register and group accumulator of the OHLC bar aggregator; uses ohlc_pkg.
// Merges one registered bar per cycle into the open group unless a full queue holds a closing bar.
`default_nettype none

module ohlc_merge (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [ohlc_pkg::GROUP_BITS-1:0]    group_size,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire ohlc_pkg::bar_in_t                  in_bar,
  output logic                                    push_valid,
  output ohlc_pkg::bar_out_t                      push_bar,
  input  wire logic                               push_space
);

  logic                                   ir_valid_r;
  ohlc_pkg::bar_in_t                      ir_bar_r;

  logic [ohlc_pkg::GROUP_BITS-1:0]        cnt_r,   cnt_nxt;
  logic [ohlc_pkg::TIME_BITS-1:0]         time_r,  time_nxt;
  logic [ohlc_pkg::PRICE_BITS-1:0]        open_r,  open_nxt;
  logic [ohlc_pkg::PRICE_BITS-1:0]        high_r,  high_nxt;
  logic [ohlc_pkg::PRICE_BITS-1:0]        low_r,   low_nxt;
  logic [ohlc_pkg::VOLUME_SUM_BITS-1:0]   vol_r,   vol_nxt;

  logic [ohlc_pkg::GROUP_BITS-1:0]        size_eff;
  logic [ohlc_pkg::GROUP_BITS-1:0]        cnt_inc;
  logic [ohlc_pkg::VOL_CALC_BITS-1:0]     vol_sum;
  logic [ohlc_pkg::VOL_CALC_BITS-1:0]     vol_max;
  logic                                   first;
  logic                                   emit;
  logic                                   consume;

  assign size_eff = (group_size < ohlc_pkg::MIN_GROUP) ? ohlc_pkg::MIN_GROUP : group_size;
  assign first    = (cnt_r == '0);
  assign cnt_inc  = cnt_r + ohlc_pkg::GROUP_BITS'(1);
  assign emit     = (cnt_inc >= size_eff) || ir_bar_r.end_of_set;
  assign consume  = ir_valid_r && (!emit || push_space);
  assign in_ready = !ir_valid_r || consume;

  assign vol_max = ohlc_pkg::VOL_CALC_BITS'({ohlc_pkg::VOLUME_SUM_BITS{1'b1}});

  always_comb begin
    // a new group starts from a zero volume
    vol_sum = (first ? '0 : ohlc_pkg::VOL_CALC_BITS'(vol_r))
            + ohlc_pkg::VOL_CALC_BITS'(ir_bar_r.bar_volume);
    vol_nxt = (vol_sum > vol_max) ? {ohlc_pkg::VOLUME_SUM_BITS{1'b1}}
                                  : ohlc_pkg::VOLUME_SUM_BITS'(vol_sum);
    time_nxt = first ? ir_bar_r.bar_time   : time_r;
    open_nxt = first ? ir_bar_r.price_open : open_r;
    high_nxt = (first || (ir_bar_r.price_high > high_r)) ? ir_bar_r.price_high : high_r;
    low_nxt  = (first || (ir_bar_r.price_low  < low_r))  ? ir_bar_r.price_low  : low_r;
    cnt_nxt  = emit ? '0 : cnt_inc;
  end

  always_comb begin
    push_valid             = ir_valid_r && emit;
    push_bar.merged_time   = time_nxt;
    push_bar.merged_open   = open_nxt;
    push_bar.merged_high   = high_nxt;
    push_bar.merged_low    = low_nxt;
    push_bar.merged_close  = ir_bar_r.price_close;
    push_bar.merged_volume = vol_nxt;
    push_bar.final_bar     = ir_bar_r.end_of_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (in_ready) begin
        ir_valid_r <= in_valid;
      end
      if (consume) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_bar_r <= in_bar;
    end
    if (consume) begin
      time_r <= time_nxt;
      open_r <= open_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      vol_r  <= vol_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/ohlc_out_fifo.sv
// Two-word result queue of the OHLC bar aggregator: decouples the merge stage from
// output stalls so a bar can be taken every cycle while a word is free; uses ohlc_pkg.
`default_nettype none

module ohlc_out_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  wire ohlc_pkg::bar_out_t push_bar,
  output logic                    push_space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ohlc_pkg::bar_out_t      out_bar
);

  ohlc_pkg::bar_out_t mem [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         count_r;
  logic               push;
  logic               pop;

  assign push_space = (count_r != 2'd2);
  assign out_valid  = (count_r != 2'd0);
  assign out_bar    = mem[rd_ptr_r];
  assign push       = push_valid && push_space;
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_bar;
    end
  end

endmodule

`default_nettype wire

// File: bench/ohlc_bar_checker.sv
// Scoreboard for the OHLC bar aggregator: watches the group size writes and both
// word channels, folds accepted bars into merged bars and compares the results.
// Depends on ohlc_pkg.
module ohlc_bar_checker import ohlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [GROUP_BITS-1:0] cfg_wr_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  bar_in_t               in_bar,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  bar_out_t              out_bar,
  output int                    mismatch_count,
  output int                    pending_bars
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [GROUP_BITS-1:0] size_reg;
  logic [GROUP_BITS-1:0] open_bars;
  bar_out_t              group_acc;
  bar_out_t              expected_bars[$];
  int                    errors = 0;

  initial begin
    mismatch_count = 0;
    pending_bars = 0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : track_bars
    bar_out_t                 want;
    logic [GROUP_BITS-1:0]    limit;
    logic [VOL_CALC_BITS-1:0] vol_sum;
    if (!rst_n) begin
      size_reg = GROUP_SIZE_RST;
      open_bars = '0;
      group_acc = '0;
      expected_bars.delete();
    end else begin
      if (cfg_wr_en) begin
        size_reg = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (expected_bars.size() == 0) begin
          report_mismatch("merged bar with none expected, time",
                          64'(out_bar.merged_time), '0);
        end else begin
          want = expected_bars.pop_front();
          if (out_bar.merged_time !== want.merged_time)
            report_mismatch("merged_time", 64'(out_bar.merged_time),
                            64'(want.merged_time));
          if (out_bar.merged_open !== want.merged_open)
            report_mismatch("merged_open", 64'(out_bar.merged_open),
                            64'(want.merged_open));
          if (out_bar.merged_high !== want.merged_high)
            report_mismatch("merged_high", 64'(out_bar.merged_high),
                            64'(want.merged_high));
          if (out_bar.merged_low !== want.merged_low)
            report_mismatch("merged_low", 64'(out_bar.merged_low),
                            64'(want.merged_low));
          if (out_bar.merged_close !== want.merged_close)
            report_mismatch("merged_close", 64'(out_bar.merged_close),
                            64'(want.merged_close));
          if (out_bar.merged_volume !== want.merged_volume)
            report_mismatch("merged_volume", 64'(out_bar.merged_volume),
                            64'(want.merged_volume));
          if (out_bar.final_bar !== want.final_bar)
            report_mismatch("final_bar", 64'(out_bar.final_bar),
                            64'(want.final_bar));
        end
      end
      if (in_valid && in_ready) begin
        // sizes below the minimum act as the minimum
        limit = (size_reg < MIN_GROUP) ? MIN_GROUP : size_reg;
        vol_sum = VOL_CALC_BITS'(in_bar.bar_volume) +
                  ((open_bars == '0) ? '0 : VOL_CALC_BITS'(group_acc.merged_volume));
        if (open_bars == '0) begin
          group_acc.merged_time = in_bar.bar_time;
          group_acc.merged_open = in_bar.price_open;
          group_acc.merged_high = in_bar.price_high;
          group_acc.merged_low  = in_bar.price_low;
        end else begin
          if (in_bar.price_high > group_acc.merged_high)
            group_acc.merged_high = in_bar.price_high;
          if (in_bar.price_low < group_acc.merged_low)
            group_acc.merged_low = in_bar.price_low;
        end
        // clamp the volume sum at all ones
        if (vol_sum > VOL_CALC_BITS'({VOLUME_SUM_BITS{1'b1}}))
          group_acc.merged_volume = '1;
        else
          group_acc.merged_volume = vol_sum[VOLUME_SUM_BITS-1:0];
        open_bars = open_bars + GROUP_BITS'(1);
        if (open_bars >= limit || in_bar.end_of_set) begin
          group_acc.merged_close = in_bar.price_close;
          group_acc.final_bar    = in_bar.end_of_set;
          expected_bars.push_back(group_acc);
          open_bars = '0;
        end
      end
    end
    mismatch_count <= errors;
    pending_bars   <= expected_bars.size();
  end

endmodule

// File: bench/ohlc_bar_aggregator_tb.sv
// Testbench top for the OHLC bar aggregator: clock, reset, bar stimulus,
// result back-pressure, watchdog and verdict.
// Depends on ohlc_pkg, ohlc_bar_aggregator and ohlc_bar_checker.
module ohlc_bar_aggregator_tb;
  import ohlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [GROUP_BITS-1:0]      cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  bar_in_t                    in_bar;
  logic                       out_valid;
  logic                       out_ready;
  logic [TIME_BITS-1:0]       out_merged_time;
  logic [PRICE_BITS-1:0]      out_merged_open;
  logic [PRICE_BITS-1:0]      out_merged_high;
  logic [PRICE_BITS-1:0]      out_merged_low;
  logic [PRICE_BITS-1:0]      out_merged_close;
  logic [VOLUME_SUM_BITS-1:0] out_merged_volume;
  logic                       out_final_bar;

  int mismatch_count;
  int pending_bars;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 0;
  int stall_cycles = 0;

  ohlc_bar_aggregator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_bar_time       (in_bar.bar_time),
    .in_price_open     (in_bar.price_open),
    .in_price_high     (in_bar.price_high),
    .in_price_low      (in_bar.price_low),
    .in_price_close    (in_bar.price_close),
    .in_bar_volume     (in_bar.bar_volume),
    .in_end_of_set     (in_bar.end_of_set),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_merged_time   (out_merged_time),
    .out_merged_open   (out_merged_open),
    .out_merged_high   (out_merged_high),
    .out_merged_low    (out_merged_low),
    .out_merged_close  (out_merged_close),
    .out_merged_volume (out_merged_volume),
    .out_final_bar     (out_final_bar)
  );

  ohlc_bar_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_bar         (in_bar),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bar        ({out_merged_time, out_merged_open, out_merged_high, out_merged_low,
                      out_merged_close, out_merged_volume, out_final_bar}),
    .mismatch_count (mismatch_count),
    .pending_bars   (pending_bars)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stall bursts plus one long hold-off on request
  initial begin : result_sink
    int  stall_left;
    int  hold_left;
    bit  hold_used;
    stall_left = 0;
    hold_left = 0;
    hold_used = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [PRICE_BITS-1:0] tick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return PRICE_BITS'(5000 + $urandom_range(0, 31));
      default: return PRICE_BITS'($urandom);
    endcase
  endfunction

  function automatic bar_in_t random_bar(int eos_odds);
    bar_in_t b;
    b.bar_time    = {16'($urandom), 32'($urandom)};
    b.price_open  = tick_value();
    b.price_high  = tick_value();
    b.price_low   = tick_value();
    b.price_close = tick_value();
    b.bar_volume  = ($urandom_range(0, 7) == 0) ? '1 : VOLUME_IN_BITS'($urandom);
    b.end_of_set  = (eos_odds > 0) && ($urandom_range(1, eos_odds) == 1);
    return b;
  endfunction

  // hold the word until it is taken; drop valid only across a gap
  task automatic offer_bar(bar_in_t b);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bar = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_run(int count, bit close_set);
    bar_in_t b;
    for (int k = 0; k < count; k++) begin
      b = random_bar(0);
      b.end_of_set = close_set && (k == count - 1);
      offer_bar(b);
    end
  endtask

  // write only once the block has drained, then let the pipeline settle
  task automatic write_group_size(logic [GROUP_BITS-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_bars != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_data = value;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin : stimulus
    bar_in_t               b;
    logic [GROUP_BITS-1:0] grp;
    int                    eos_odds;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_bar = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 25;
    // reset size of two: all-zero bar then all-ones bar
    b = '0;
    offer_bar(b);
    b.bar_time    = '1;
    b.price_open  = '1;
    b.price_high  = '1;
    b.price_low   = '1;
    b.price_close = '1;
    b.bar_volume  = '1;
    offer_bar(b);
    // lone bar closed by end of set
    b = random_bar(0);
    b.end_of_set = 1'b1;
    offer_bar(b);
    // second bar neither raises the high nor lowers the low
    b = random_bar(0);
    b.price_high = 32'd900;
    b.price_low  = 32'd100;
    offer_bar(b);
    b.price_high = 32'd800;
    b.price_low  = 32'd200;
    offer_bar(b);
    // sizes of zero and one act as two
    write_group_size(16'd0);
    offer_run(2, 0);
    write_group_size(16'd1);
    offer_run(3, 1);
    // largest size, closed early by end of set
    write_group_size(16'hFFFF);
    offer_run(4, 1);
    // shrink the size under an open group: next bar closes it
    write_group_size(16'd8);
    offer_run(5, 0);
    write_group_size(16'd3);
    offer_run(1, 0);
    write_group_size(16'd5);
    offer_run(3, 0);
    write_group_size(16'd4);
    offer_run(1, 0);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       grp = 16'd2;
        1:       grp = 16'd3;
        2:       grp = 16'd7;
        3:       grp = 16'd1;
        4:       grp = 16'd0;
        5:       grp = GROUP_BITS'($urandom_range(2, 12));
        6:       grp = 16'd16;
        7:       grp = 16'hFFFF;
        8:       grp = 16'd4;
        default: grp = 16'd2;
      endcase
      write_group_size(grp);
      eos_odds = (grp == 16'hFFFF) ? 6 : 25;
      if (p == 9) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
      for (int i = 0; i < 155; i++) begin
        if (p == 2 && i == 20)
          hold_req = 1;
        offer_bar(random_bar(eos_odds));
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_bars != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
